/* rtl/core/ihex_pkg.sv */
// Shared types, codes and helpers for the Intel HEX record parser.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

   localparam logic [7:0] COLON_CHAR = 8'h3A;

   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;
   localparam logic [1:0] PH_CHECK  = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EOF   = 3'd1;
   localparam logic [2:0] ST_CSUM  = 3'd2;
   localparam logic [2:0] ST_TYPE  = 3'd3;
   localparam logic [2:0] ST_TRUNC = 3'd4;
   localparam logic [2:0] ST_END   = 3'd5;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [7:0] TYPE_DATA = 8'd0;
   localparam logic [7:0] TYPE_EOF  = 8'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] byte_address;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic [7:0]  record_length;
      logic [7:0]  longest_length;
      logic        last_result;
   } rsp_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h37);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ihex_core.sv */
// Per-character parse state and result generation for the Intel HEX parser.
`timescale 1ns / 1ps
`default_nettype none

module ihex_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire ihex_pkg::req_type item,
   output logic [1:0]             push_count,
   output ihex_pkg::rsp_type      result0,
   output ihex_pkg::rsp_type      result1
);

   logic [1:0]  phase_ff, phase_in;
   logic        pend_ff, pend_in;
   logic [3:0]  hi_ff, hi_in;
   logic [1:0]  hidx_ff, hidx_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  didx_ff, didx_in;
   logic [7:0]  max_ff, max_in;
   logic        stop_ff, stop_in;

   logic [3:0]  nib;
   logic [7:0]  bval;
   logic        done;
   logic [2:0]  st;
   logic [1:0]  n;
   ihex_pkg::rsp_type r0, r1;

   assign nib  = ihex_pkg::nibble_of(item.text_char);
   assign bval = {hi_ff, nib};

   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      hi_in    = hi_ff;
      hidx_in  = hidx_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      addr_in  = addr_ff;
      type_in  = type_ff;
      didx_in  = didx_ff;
      max_in   = max_ff;
      stop_in  = stop_ff;
      done     = 1'b0;
      st       = ihex_pkg::ST_OK;
      n        = 2'd0;
      r0       = '0;
      r1       = '0;
      if (accept && !stop_ff) begin
         if (phase_ff == ihex_pkg::PH_HUNT) begin
            if (item.text_char == ihex_pkg::COLON_CHAR) begin
               phase_in = ihex_pkg::PH_HEADER;
               pend_in  = 1'b0;
               hi_in    = 4'd0;
               hidx_in  = 2'd0;
               sum_in   = 8'd0;
               len_in   = 8'd0;
               addr_in  = 16'd0;
               type_in  = 8'd0;
               didx_in  = 8'd0;
               if (item.end_of_text) begin
                  r0.kind   = ihex_pkg::KIND_STATUS;
                  r0.status = ihex_pkg::ST_TRUNC;
                  n         = 2'd1;
                  stop_in   = 1'b1;
               end
            end else if (item.end_of_text) begin
               r0.kind   = ihex_pkg::KIND_STATUS;
               r0.status = ihex_pkg::ST_END;
               n         = 2'd1;
               stop_in   = 1'b1;
            end
         end else if (!pend_ff) begin
            hi_in   = nib;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
            sum_in  = sum_ff + bval;
            case (phase_ff)
               ihex_pkg::PH_HEADER: begin
                  case (hidx_ff)
                     2'd0:    len_in = bval;
                     2'd1:    addr_in[15:8] = bval;
                     2'd2:    addr_in[7:0] = bval;
                     default: type_in = bval;
                  endcase
                  if (hidx_ff == 2'd3) begin
                     hidx_in  = 2'd0;
                     didx_in  = 8'd0;
                     phase_in = (len_ff != 8'd0) ? ihex_pkg::PH_DATA : ihex_pkg::PH_CHECK;
                  end else begin
                     hidx_in = hidx_ff + 2'd1;
                  end
               end
               ihex_pkg::PH_DATA: begin
                  r0.kind          = ihex_pkg::KIND_DATA;
                  r0.byte_address  = addr_ff + {8'd0, didx_ff};
                  r0.data_byte     = bval;
                  r0.record_length = len_ff;
                  n                = 2'd1;
                  didx_in          = didx_ff + 8'd1;
                  if (didx_in == len_ff) begin
                     phase_in = ihex_pkg::PH_CHECK;
                  end
               end
               default: begin
                  if (sum_in != 8'd0) begin
                     st = ihex_pkg::ST_CSUM;
                  end else if (type_ff == ihex_pkg::TYPE_EOF || len_ff == 8'd0) begin
                     st = ihex_pkg::ST_EOF;
                  end else if (type_ff == ihex_pkg::TYPE_DATA) begin
                     st = ihex_pkg::ST_OK;
                  end else begin
                     st = ihex_pkg::ST_TYPE;
                  end
                  done     = 1'b1;
                  phase_in = ihex_pkg::PH_HUNT;
                  if (st == ihex_pkg::ST_OK) begin
                     if (len_ff > max_ff) begin
                        max_in = len_ff;
                     end
                  end else begin
                     stop_in = 1'b1;
                  end
                  r0.kind          = ihex_pkg::KIND_STATUS;
                  r0.status        = st;
                  r0.record_length = len_ff;
                  n                = 2'd1;
                  if (st == ihex_pkg::ST_OK && item.end_of_text) begin
                     r1.kind   = ihex_pkg::KIND_STATUS;
                     r1.status = ihex_pkg::ST_END;
                     n         = 2'd2;
                     stop_in   = 1'b1;
                  end
               end
            endcase
         end
         if (!stop_in && item.end_of_text && phase_in != ihex_pkg::PH_HUNT && !done) begin
            if (n == 2'd0) begin
               r0.kind          = ihex_pkg::KIND_STATUS;
               r0.status        = ihex_pkg::ST_TRUNC;
               r0.record_length = len_in;
            end else begin
               r1.kind          = ihex_pkg::KIND_STATUS;
               r1.status        = ihex_pkg::ST_TRUNC;
               r1.record_length = len_in;
            end
            n       = n + 2'd1;
            stop_in = 1'b1;
         end
      end
      r0.longest_length = max_in;
      r1.longest_length = max_in;
      r0.last_result    = (n == 2'd1);
      r1.last_result    = (n == 2'd2);
   end

   assign push_count = n;
   assign result0    = r0;
   assign result1    = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ihex_pkg::PH_HUNT;
         pend_ff  <= 1'b0;
         hi_ff    <= 4'd0;
         hidx_ff  <= 2'd0;
         sum_ff   <= 8'd0;
         len_ff   <= 8'd0;
         addr_ff  <= 16'd0;
         type_ff  <= 8'd0;
         didx_ff  <= 8'd0;
         max_ff   <= 8'd0;
         stop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         hi_ff    <= hi_in;
         hidx_ff  <= hidx_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         addr_ff  <= addr_in;
         type_ff  <= type_in;
         didx_ff  <= didx_in;
         max_ff   <= max_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/intel_hex_record_parser.sv */
// Top level of the Intel HEX record parser: parse core and result queue.
// Results are registered in the result queue and offered on rsp_ in order from its head.
// Throughput: one character per cycle while req_stall is low; a character gives at most two results.
// Input stalls only while the four-entry result queue has fewer than two free slots.
// Reset clears parse state, longest length and the queue; parsing resumes at colon hunt.
// After eof, an error or end of text every character is taken and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ihex_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ihex_pkg::rsp_type      rsp_data
);

   localparam int AW = ihex_pkg::QUEUE_AW;
   localparam int CW = ihex_pkg::QUEUE_AW + 1;

   logic              accept;
   logic              pop;
   logic [1:0]        push_count;
   ihex_pkg::rsp_type result0, result1;

   ihex_pkg::rsp_type q_ff [ihex_pkg::QUEUE_DEPTH];
   logic [AW-1:0]     wr_ff, wr_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     count_ff, count_in;

   assign req_stall = (count_ff > CW'(ihex_pkg::QUEUE_DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;

   ihex_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .item       (req_data),
      .push_count (push_count),
      .result0    (result0),
      .result1    (result1)
   );

   always_comb begin
      wr_in    = wr_ff + AW'(push_count);
      rd_in    = rd_ff + AW'(pop);
      count_in = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         q_ff[wr_ff] <= result0;
      end
      if (push_count == 2'd2) begin
         q_ff[wr_ff + AW'(1)] <= result1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* tb/ihex_checker.sv */
// Checker for the Intel HEX parser: predicts results from accepted characters and compares.
`timescale 1ns / 1ps

module ihex_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  ihex_pkg::req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  ihex_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               outstanding
);
   import ihex_pkg::*;

   logic [1:0]  phase;
   logic        nib_held;
   logic [3:0]  nib_hi;
   logic [1:0]  hdr_idx;
   logic [7:0]  sum;
   logic [7:0]  rec_len;
   logic [15:0] rec_addr;
   logic [7:0]  rec_type;
   logic [7:0]  data_idx;
   logic [7:0]  longest;
   logic        halted;

   rsp_type awaited_results[$];

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic rsp_type result_of(input logic kind, input logic [15:0] addr,
                                         input logic [7:0] value, input logic [2:0] st,
                                         input logic [7:0] len);
      rsp_type r;
      r.kind           = kind;
      r.byte_address   = addr;
      r.data_byte      = value;
      r.status         = st;
      r.record_length  = len;
      r.longest_length = longest;
      r.last_result    = 1'b0;
      return r;
   endfunction

   task automatic decode_char(input req_type t);
      rsp_type    step_out[$];
      logic [7:0] pair;
      logic [2:0] st;
      logic       closed;
      if (halted) return;
      closed = 1'b0;
      if (phase == PH_HUNT) begin
         if (t.text_char == COLON_CHAR) begin
            phase    = PH_HEADER;
            nib_held = 1'b0;
            nib_hi   = 4'd0;
            hdr_idx  = 2'd0;
            sum      = 8'd0;
            rec_len  = 8'd0;
            rec_addr = 16'd0;
            rec_type = 8'd0;
            data_idx = 8'd0;
            if (t.end_of_text) begin
               step_out.push_back(result_of(KIND_STATUS, 16'd0, 8'd0, ST_TRUNC, 8'd0));
               halted = 1'b1;
            end
         end else if (t.end_of_text) begin
            step_out.push_back(result_of(KIND_STATUS, 16'd0, 8'd0, ST_END, 8'd0));
            halted = 1'b1;
         end
      end else if (!nib_held) begin
         nib_hi   = hex_value(t.text_char);
         nib_held = 1'b1;
      end else begin
         pair     = {nib_hi, hex_value(t.text_char)};
         nib_held = 1'b0;
         sum      = sum + pair;
         if (phase == PH_HEADER) begin
            case (hdr_idx)
               2'd0: rec_len = pair;
               2'd1: rec_addr[15:8] = pair;
               2'd2: rec_addr[7:0] = pair;
               default: rec_type = pair;
            endcase
            if (hdr_idx == 2'd3) begin
               hdr_idx  = 2'd0;
               data_idx = 8'd0;
               phase    = (rec_len != 8'd0) ? PH_DATA : PH_CHECK;
            end else begin
               hdr_idx = hdr_idx + 2'd1;
            end
         end else if (phase == PH_DATA) begin
            step_out.push_back(result_of(KIND_DATA, rec_addr + 16'(data_idx), pair,
                                         ST_OK, rec_len));
            data_idx = data_idx + 8'd1;
            if (data_idx == rec_len) phase = PH_CHECK;
         end else begin
            // checksum beats eof, eof beats type
            if (sum != 8'd0) st = ST_CSUM;
            else if (rec_type == TYPE_EOF || rec_len == 8'd0) st = ST_EOF;
            else if (rec_type == TYPE_DATA) st = ST_OK;
            else st = ST_TYPE;
            closed = 1'b1;
            phase  = PH_HUNT;
            if (st == ST_OK) begin
               if (rec_len > longest) longest = rec_len;
            end else begin
               halted = 1'b1;
            end
            step_out.push_back(result_of(KIND_STATUS, 16'd0, 8'd0, st, rec_len));
            if (st == ST_OK && t.end_of_text) begin
               step_out.push_back(result_of(KIND_STATUS, 16'd0, 8'd0, ST_END, 8'd0));
               halted = 1'b1;
            end
         end
      end
      if (!halted && t.end_of_text && phase != PH_HUNT && !closed) begin
         step_out.push_back(result_of(KIND_STATUS, 16'd0, 8'd0, ST_TRUNC, rec_len));
         halted = 1'b1;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last_result = 1'b1;
      foreach (step_out[i]) awaited_results.push_back(step_out[i]);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase      = PH_HUNT;
         nib_held   = 1'b0;
         nib_hi     = 4'd0;
         hdr_idx    = 2'd0;
         sum        = 8'd0;
         rec_len    = 8'd0;
         rec_addr   = 16'd0;
         rec_type   = 8'd0;
         data_idx   = 8'd0;
         longest    = 8'd0;
         halted     = 1'b0;
         fail_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with nothing awaited");
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("kind", 16'(want.kind), 16'(rsp_data.kind));
               compare_field("byte_address", want.byte_address, rsp_data.byte_address);
               compare_field("data_byte", 16'(want.data_byte), 16'(rsp_data.data_byte));
               compare_field("status", 16'(want.status), 16'(rsp_data.status));
               compare_field("record_length", 16'(want.record_length),
                             16'(rsp_data.record_length));
               compare_field("longest_length", 16'(want.longest_length),
                             16'(rsp_data.longest_length));
               compare_field("last_result", 16'(want.last_result),
                             16'(rsp_data.last_result));
            end
         end
         if (req_valid && !req_stall) decode_char(req_data);
      end
      outstanding <= awaited_results.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top for the Intel HEX parser: builds the text, drives it and reports the verdict.
`timescale 1ns / 1ps

module tb;
   import ihex_pkg::*;

   localparam int TEXT_CHARS  = 1650;
   localparam int QUIET_LIMIT = 2000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;
   int      quiet_cycles = 0;

   req_type    hex_text[$];
   logic [7:0] sum_acc;
   int         junk_pct = 10;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   intel_hex_record_parser u_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   ihex_checker u_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .fail_count,
      .outstanding
   );

   // any non-hex character decodes as nibble zero
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      case ($urandom_range(3))
         0: c = COLON_CHAR;
         1: c = 8'($urandom_range(8'h80, 8'hFF));
         2: c = 8'($urandom_range(8'h00, 8'h2F));
         default: c = 8'($urandom_range(8'h67, 8'h7A));
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n == 4'd0 && $urandom_range(99) < junk_pct) return junk_char();
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n - 4'd10);
   endfunction

   task automatic push_char(input logic [7:0] c, input logic eot);
      req_type t;
      t.text_char   = c;
      t.end_of_text = eot;
      hex_text.push_back(t);
   endtask

   task automatic put_byte(input logic [7:0] b);
      push_char(hex_char(b[7:4]), 1'b0);
      push_char(hex_char(b[3:0]), 1'b0);
      sum_acc = sum_acc + b;
   endtask

   task automatic add_record(input int len, input logic [15:0] addr, input logic [7:0] rtype,
                             input int fill, input bit corrupt);
      logic [7:0] tail;
      push_char(COLON_CHAR, 1'b0);
      sum_acc = 8'd0;
      put_byte(8'(len));
      put_byte(addr[15:8]);
      put_byte(addr[7:0]);
      put_byte(rtype);
      for (int i = 0; i < len; i++) put_byte(fill < 0 ? 8'($urandom) : 8'(fill));
      tail = 8'd0 - sum_acc;
      if (corrupt) tail = tail + 8'($urandom_range(1, 255));
      put_byte(tail);
   endtask

   task automatic add_noise(input int count);
      logic [7:0] c;
      for (int i = 0; i < count; i++) begin
         c = 8'($urandom_range(255));
         if (c == COLON_CHAR) c = 8'h3B;
         push_char(c, 1'b0);
      end
   endtask

   task automatic mark_end();
      req_type t;
      t = hex_text.pop_back();
      t.end_of_text = 1'b1;
      hex_text.push_back(t);
   endtask

   task automatic build_text();
      int start_at;
      int kept;
      int len;
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b0);
      push_char(8'h7F, 1'b0);
      junk_pct = 60;
      add_record(1, 16'h0000, TYPE_DATA, 0, 1'b0);
      junk_pct = 10;
      add_record(16, 16'hFFF8, TYPE_DATA, 8'hFF, 1'b0);
      add_record(255, 16'($urandom), TYPE_DATA, -1, 1'b0);
      add_noise(2);
      add_record(3, 16'h1234, TYPE_DATA, -1, 1'b0);
      while (hex_text.size() < TEXT_CHARS) begin
         add_noise($urandom_range(0, 3));
         len = ($urandom_range(24) == 0) ? $urandom_range(17, 255) : $urandom_range(1, 16);
         add_record(len, 16'($urandom), TYPE_DATA, -1, 1'b0);
      end
      // the parser stops for good on this record, so one closing case per run
      case ($urandom_range(7))
         0: add_record(0, 16'h0000, TYPE_EOF, -1, 1'b0);
         1: add_record(0, 16'($urandom), TYPE_DATA, -1, 1'b0);
         2: add_record($urandom_range(1, 8), 16'($urandom), TYPE_EOF, -1, 1'b0);
         3: add_record($urandom_range(1, 8), 16'($urandom), 8'($urandom), -1, 1'b1);
         4: add_record($urandom_range(1, 8), 16'($urandom), 8'($urandom_range(2, 255)),
                       -1, 1'b0);
         5: begin
            start_at = hex_text.size();
            add_record($urandom_range(1, 8), 16'($urandom), TYPE_DATA, -1, 1'b0);
            kept = $urandom_range(1, hex_text.size() - start_at - 1);
            while (hex_text.size() > start_at + kept) void'(hex_text.pop_back());
            mark_end();
         end
         6: begin
            add_record($urandom_range(1, 16), 16'($urandom), TYPE_DATA, -1, 1'b0);
            mark_end();
         end
         default: push_char(8'h0A, 1'b1);
      endcase
      // dropped by the stopped parser
      for (int i = 0; i < 12; i++) push_char(8'($urandom), 1'($urandom));
   endtask

   initial begin
      int offered;
      int accepted;
      int send_idle;
      int recv_stall;
      offered  = 0;
      accepted = 0;
      build_text();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (accepted < hex_text.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) accepted++;
         if (accepted < hex_text.size() / 3) begin
            send_idle  = 20;
            recv_stall = 58;
         end else if (accepted < 2 * hex_text.size() / 3) begin
            send_idle  = 58;
            recv_stall = 20;
         end else begin
            send_idle  = 0;
            recv_stall = 0;
         end
         if (!req_valid || !req_stall) begin
            if (offered < hex_text.size() && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_data  <= hex_text[offered];
               offered++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= 1'($urandom_range(99) < recv_stall);
      end
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* files.f */
rtl/core/ihex_pkg.sv
rtl/core/ihex_core.sv
rtl/core/intel_hex_record_parser.sv
tb/ihex_checker.sv
tb/tb.sv
